// ----- hdl/ptt_pkg.sv -----
package ptt_pkg;

   localparam int SLOTS      = 16;
   localparam int COUNT_BITS = 32;
   localparam int PERIOD_BITS = 32;
   localparam int ID_BITS    = 4;

   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDW       = (SLOT_BITS > ID_BITS) ? SLOT_BITS : ID_BITS;
   localparam int CMP_BITS  = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

   localparam logic [1:0] REQ_TICK         = 2'd0;
   localparam logic [1:0] REQ_ADD_PERIODIC = 2'd1;
   localparam logic [1:0] REQ_ADD_ONE_SHOT = 2'd2;
   localparam logic [1:0] REQ_DELETE       = 2'd3;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_DEL  = 2'd1;
   localparam logic [1:0] KIND_FIRE = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [1:0] ST_BAD_PERIOD = 2'd3;

   typedef struct packed {
      logic                   valid;
      logic                   one_shot;
      logic [PERIOD_BITS-1:0] period;
      logic [COUNT_BITS-1:0]  count;
   } slot_type;

   typedef struct packed {
      logic fire;
      logic claim;
      logic hit;
   } ev_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [ID_BITS-1:0] slot_id;
      logic [1:0]         status;
   } res_type;

   function automatic logic [ID_BITS-1:0] to_id(input logic [SLOT_BITS-1:0] idx);
      logic [IDW-1:0] w;
      w = IDW'(idx);
      return w[ID_BITS-1:0];
   endfunction

endpackage

// ----- hdl/ptt_if.sv -----
interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] period;
   logic [3:0]  handle;

   modport source (output valid, output req_type, output period, output handle, input ready);
   modport sink   (input valid, input req_type, input period, input handle, output ready);
endinterface

interface ptt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] slot_id;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output kind, output slot_id, output status, output last,
                   input ready);
   modport sink   (input valid, input kind, input slot_id, input status, input last,
                   output ready);
endinterface

// ----- hdl/periodic_timeout_task_table.sv -----
// channel | dir | word                                   | accepted when
// req_ch  | in  | req_type, period, handle               | valid & ready
// rsp_ch  | out | kind, slot_id, status, last            | valid & ready
//
// Slots sit in a ring of cells; every request but a zero-period add rotates the ring
// once, one slot per cycle through the head logic unless the output stalls the walk:
// states idle, walk (each slot in turn) and finish; a zero-period add skips the walk.
// Reset clears slot valid marks, the control state and rsp valid. req ready is high
// only while idle; rsp is a register. A held rsp word stalls the walk when another fire
// word needs the output, and the finish state until the final word loads.
module periodic_timeout_task_table (
   input logic       clock,
   input logic       reset,
   ptt_req_if.sink   req_ch,
   ptt_rsp_if.source rsp_ch
);
   import ptt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_type;

   state_type              state_ff;
   logic [1:0]             op_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [3:0]             handle_ff;
   logic [SLOT_BITS-1:0]   step_ff;
   logic                   pend_valid_ff;
   res_type                pend_ff;
   logic                   rsp_valid_ff;
   res_type                rsp_res_ff;
   logic                   rsp_last_ff;

   slot_type               ring_q [SLOTS];
   slot_type               head_d;
   ev_type                 ev;
   logic                   out_free;
   logic                   advance;
   logic                   shift;
   logic                   rsp_load;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = !(ev.fire && pend_valid_ff && !out_free);
   assign shift    = (state_ff == S_WALK) && advance;
   assign rsp_load = ((state_ff == S_WALK) && advance && ev.fire && pend_valid_ff) ||
                     ((state_ff == S_FINISH) && pend_valid_ff && out_free);

   for (genvar j = 0; j < SLOTS; j++) begin : g_ring
      slot_type nxt;
      if (j == SLOTS - 1) begin : g_tail
         assign nxt = head_d;
      end else begin : g_mid
         assign nxt = ring_q[j+1];
      end
      ptt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .slot_in  (nxt),
         .slot_out (ring_q[j])
      );
   end

   ptt_head u_head (
      .slot_q  (ring_q[0]),
      .op      (op_ff),
      .period  (period_ff),
      .handle  (handle_ff),
      .step    (step_ff),
      .claimed (pend_ff.status == ST_OK),
      .slot_d  (head_d),
      .ev      (ev)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ch.ready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff     <= req_ch.req_type;
                  period_ff <= req_ch.period;
                  handle_ff <= req_ch.handle;
                  step_ff   <= '0;
                  state_ff  <= S_WALK;
                  unique case (req_ch.req_type)
                     REQ_TICK: begin
                        pend_valid_ff <= 1'b0;
                     end
                     REQ_ADD_PERIODIC, REQ_ADD_ONE_SHOT: begin
                        pend_valid_ff <= 1'b1;
                        if (req_ch.period == '0) begin
                           pend_ff  <= '{kind: KIND_ADD, slot_id: '0, status: ST_BAD_PERIOD};
                           state_ff <= S_FINISH;
                        end else begin
                           pend_ff <= '{kind: KIND_ADD, slot_id: '0, status: ST_FULL};
                        end
                     end
                     REQ_DELETE: begin
                        pend_valid_ff <= 1'b1;
                        pend_ff <= '{kind: KIND_DEL, slot_id: req_ch.handle,
                                     status: ST_NOT_FOUND};
                     end
                     default: begin
                        pend_valid_ff <= 1'b0;
                     end
                  endcase
               end
            end
            S_WALK: begin
               if (advance) begin
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == SLOT_BITS'(SLOTS - 1)) state_ff <= S_FINISH;
                  if (ev.fire) begin
                     if (pend_valid_ff) begin
                        rsp_res_ff   <= pend_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_ff <= '{kind: KIND_FIRE, slot_id: to_id(step_ff), status: ST_OK};
                  end
                  if (ev.claim) begin
                     pend_ff.slot_id <= to_id(step_ff);
                     pend_ff.status  <= ST_OK;
                  end
                  if (ev.hit) pend_ff.status <= ST_OK;
               end
            end
            S_FINISH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_res_ff    <= pend_ff;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.kind    = rsp_res_ff.kind;
   assign rsp_ch.slot_id = rsp_res_ff.slot_id;
   assign rsp_ch.status  = rsp_res_ff.status;
   assign rsp_ch.last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending word left while idle");

   a_stall_holds_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && !advance) |=> $stable(step_ff) && (state_ff == S_WALK))
      else $error("walk moved during output stall");

   a_fire_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && advance && ev.fire && pend_valid_ff) |=> rsp_valid_ff)
      else $error("earlier fire word dropped");
`endif
endmodule

// ----- hdl/ptt_cell.sv -----
module ptt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  ptt_pkg::slot_type slot_in,
   output ptt_pkg::slot_type slot_out
);
   import ptt_pkg::*;

   logic                   valid_ff;
   logic                   one_shot_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [COUNT_BITS-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         one_shot_ff <= 1'b0;
      end else if (shift) begin
         valid_ff    <= slot_in.valid;
         one_shot_ff <= slot_in.one_shot;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         period_ff <= slot_in.period;
         count_ff  <= slot_in.count;
      end
   end

   assign slot_out = '{valid: valid_ff, one_shot: one_shot_ff,
                       period: period_ff, count: count_ff};
endmodule

// ----- hdl/ptt_head.sv -----
module ptt_head (
   input  ptt_pkg::slot_type           slot_q,
   input  logic [1:0]                  op,
   input  logic [31:0]                 period,
   input  logic [3:0]                  handle,
   input  logic [ptt_pkg::SLOT_BITS-1:0] step,
   input  logic                        claimed,
   output ptt_pkg::slot_type           slot_d,
   output ptt_pkg::ev_type             ev
);
   import ptt_pkg::*;

   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  match;

   assign cnt_inc = slot_q.count + 1'b1;
   assign match   = (CMP_BITS'(cnt_inc) == CMP_BITS'(slot_q.period));

   always_comb begin
      slot_d = slot_q;
      ev     = '0;
      unique case (op)
         REQ_TICK: begin
            if (slot_q.valid) begin
               slot_d.count = cnt_inc;
               if (match) begin
                  slot_d.count = '0;
                  ev.fire      = 1'b1;
                  if (slot_q.one_shot) slot_d.valid = 1'b0;
               end
            end
         end
         REQ_ADD_PERIODIC, REQ_ADD_ONE_SHOT: begin
            if (!slot_q.valid && !claimed) begin
               slot_d.valid    = 1'b1;
               slot_d.one_shot = (op == REQ_ADD_ONE_SHOT);
               slot_d.period   = period;
               slot_d.count    = '0;
               ev.claim        = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (slot_q.valid && (IDW'(handle) == IDW'(step))) begin
               slot_d.valid    = 1'b0;
               slot_d.one_shot = 1'b0;
               ev.hit          = 1'b1;
            end
         end
         default: begin
            slot_d = slot_q;
         end
      endcase
   end
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import ptt_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 225;
   localparam int HOLD_CYCLES  = 250;
   localparam int HOLD_AT_ITEM = 60;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [1:0]  req_type;
      logic [31:0] period;
      logic [3:0]  handle;
   } timer_req_type;

   typedef struct {
      logic [1:0]         kind;
      logic [ID_BITS-1:0] slot_id;
      logic [1:0]         status;
      logic               last;
   } timer_word_type;

   logic clock = 1'b0;
   logic reset;

   ptt_req_if req_ch();
   ptt_rsp_if rsp_ch();

   periodic_timeout_task_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the timer table
   logic                  tbl_valid    [SLOTS];
   logic                  tbl_one_shot [SLOTS];
   logic [PERIOD_BITS-1:0] tbl_period  [SLOTS];
   logic [COUNT_BITS-1:0]  tbl_count   [SLOTS];

   timer_req_type  pending_reqs[$];
   timer_word_type expected_words[$];
   timer_req_type  on_wire;

   int errors = 0;
   int accepted_count = 0;
   int hold_left;
   bit hold_done;
   int cycle_count = 0;
   logic calm;

   assign calm = (accepted_count >= 140) && (accepted_count < 200);

   always #4 clock = ~clock;

   function automatic timer_req_type mk_req(logic [1:0] t, logic [31:0] p, logic [3:0] h);
      timer_req_type r;
      r.req_type = t;
      r.period   = p;
      r.handle   = h;
      return r;
   endfunction

   function automatic void enqueue_req(timer_req_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic timer_req_type random_req();
      timer_req_type r;
      int sel;
      int psel;
      sel  = int'($urandom_range(99));
      psel = int'($urandom_range(99));
      if (sel < 40)
         r.req_type = REQ_TICK;
      else if (sel < 55)
         r.req_type = REQ_ADD_PERIODIC;
      else if (sel < 70)
         r.req_type = REQ_ADD_ONE_SHOT;
      else
         r.req_type = REQ_DELETE;
      if (psel < 4)
         r.period = '0;
      else if (psel < 12)
         r.period = $urandom;
      else
         r.period = $urandom_range(8, 1);
      r.handle = 4'($urandom_range(15));
      return r;
   endfunction

   function automatic void push_word(logic [1:0] k, int id, logic [1:0] st, logic lst);
      timer_word_type w;
      w.kind    = k;
      w.slot_id = ID_BITS'(id);
      w.status  = st;
      w.last    = lst;
      expected_words = {expected_words, w};
   endfunction

   function automatic void predict_request(timer_req_type r);
      int fired;
      bit claimed;
      fired   = 0;
      claimed = 0;
      case (r.req_type)
         REQ_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_valid[i]) begin
                  tbl_count[i] = tbl_count[i] + 1'b1;
                  if (CMP_BITS'(tbl_count[i]) == CMP_BITS'(tbl_period[i])) begin
                     tbl_count[i] = '0;
                     if (tbl_one_shot[i])
                        tbl_valid[i] = 1'b0;
                     push_word(KIND_FIRE, i, ST_OK, 1'b0);
                     fired++;
                  end
               end
            end
            if (fired > 0)
               expected_words[expected_words.size()-1].last = 1'b1;
         end
         REQ_ADD_PERIODIC, REQ_ADD_ONE_SHOT: begin
            if (r.period == '0) begin
               push_word(KIND_ADD, 0, ST_BAD_PERIOD, 1'b1);
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!claimed && !tbl_valid[i]) begin
                     claimed         = 1;
                     tbl_valid[i]    = 1'b1;
                     tbl_one_shot[i] = (r.req_type == REQ_ADD_ONE_SHOT);
                     tbl_period[i]   = PERIOD_BITS'(r.period);
                     tbl_count[i]    = '0;
                     push_word(KIND_ADD, i, ST_OK, 1'b1);
                  end
               end
               if (!claimed)
                  push_word(KIND_ADD, 0, ST_FULL, 1'b1);
            end
         end
         default: begin
            if (int'(r.handle) < SLOTS && tbl_valid[r.handle]) begin
               tbl_valid[r.handle]    = 1'b0;
               tbl_one_shot[r.handle] = 1'b0;
               push_word(KIND_DEL, int'(r.handle), ST_OK, 1'b1);
            end else begin
               push_word(KIND_DEL, int'(r.handle), ST_NOT_FOUND, 1'b1);
            end
         end
      endcase
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: rsp %s expected %0d got %0d", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   task automatic check_word();
      timer_word_type w;
      if (expected_words.size() == 0) begin
         $display("%0t: rsp word with none expected, kind %0d slot %0d status %0d last %0d",
                  $time, rsp_ch.kind, rsp_ch.slot_id, rsp_ch.status, rsp_ch.last);
         errors++;
      end else begin
         w = expected_words.pop_front();
         check_field("kind", w.kind, rsp_ch.kind);
         check_field("slot_id", w.slot_id, rsp_ch.slot_id);
         check_field("status", w.status, rsp_ch.status);
         check_field("last", w.last, rsp_ch.last);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i]    = 1'b0;
            tbl_one_shot[i] = 1'b0;
            tbl_period[i]   = '0;
            tbl_count[i]    = '0;
         end
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_request(on_wire);
            accepted_count <= accepted_count + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
               on_wire = pending_reqs.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.req_type <= on_wire.req_type;
               req_ch.period   <= on_wire.period;
               req_ch.handle   <= on_wire.handle;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once, while requests keep coming
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_count == HOLD_AT_ITEM) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_word();
         rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 7);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[periodic_timeout_task_table] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;

      // empty table: silent tick, misses, zero periods
      enqueue_req(mk_req(REQ_TICK, 32'hFFFF_FFFF, 4'hF));
      enqueue_req(mk_req(REQ_DELETE, '0, 4'h0));
      enqueue_req(mk_req(REQ_DELETE, 32'hFFFF_FFFF, 4'hF));
      enqueue_req(mk_req(REQ_ADD_PERIODIC, '0, 4'h0));
      enqueue_req(mk_req(REQ_ADD_ONE_SHOT, '0, 4'hF));
      // fill every slot, then overflow
      enqueue_req(mk_req(REQ_ADD_PERIODIC, 32'd1, 4'h0));
      enqueue_req(mk_req(REQ_ADD_ONE_SHOT, 32'd2, 4'h0));
      enqueue_req(mk_req(REQ_ADD_PERIODIC, 32'hFFFF_FFFF, 4'h0));
      enqueue_req(mk_req(REQ_ADD_ONE_SHOT, 32'd3, 4'h0));
      for (int k = 4; k < SLOTS; k++)
         enqueue_req(mk_req(REQ_ADD_PERIODIC, 32'd2, 4'(k)));
      enqueue_req(mk_req(REQ_ADD_ONE_SHOT, 32'd5, 4'h5));
      // fires, one-shots retire
      repeat (3) enqueue_req(mk_req(REQ_TICK, '0, '0));
      enqueue_req(mk_req(REQ_DELETE, '0, 4'h2));
      enqueue_req(mk_req(REQ_DELETE, '0, 4'h2));

      repeat (RANDOM_ITEMS) enqueue_req(random_req());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("[periodic_timeout_task_table] OK");
      end else begin
         $display("[periodic_timeout_task_table] ERROR");
      end
      $finish;
   end

endmodule
